// File: sv/pee_pkg.sv
// prefix expression evaluator package: token codes, operation and state types,
// and the control structs passed between the sequencer, stack and arithmetic unit
// no dependencies
package pee_pkg;

    localparam int TOKEN_COUNT = 8;
    localparam int TOKEN_W     = 4;
    localparam int TOK_IDX_W   = $clog2(TOKEN_COUNT);
    localparam int DEPTH_W     = $clog2(TOKEN_COUNT + 1);
    localparam int X_W         = 32;
    localparam int RESULT_W    = 32;

    localparam logic [TOKEN_W-1:0] TK_DIGIT_MAX = 4'd9;
    localparam logic [TOKEN_W-1:0] TK_X         = 4'd10;
    localparam logic [TOKEN_W-1:0] TK_ADD       = 4'd11;
    localparam logic [TOKEN_W-1:0] TK_SUB       = 4'd12;
    localparam logic [TOKEN_W-1:0] TK_MUL       = 4'd13;
    localparam logic [TOKEN_W-1:0] TK_DIV       = 4'd14;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOKEN,
        S_POP_B,
        S_LOAD,
        S_ALU,
        S_FINAL,
        S_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_DONE
    } t_alu_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

// File: sv/pee_stack.sv
// operand stack of the prefix expression evaluator: small memory with depth count
// and a registered read port; a pop of an empty stack reads zero
// depends on pee_pkg
module pee_stack import pee_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_stk_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_data,
    output logic [VALUE_WIDTH-1:0] o_data
);

    logic [VALUE_WIDTH-1:0] r_mem [TOKEN_COUNT];
    logic [VALUE_WIDTH-1:0] r_rd;
    logic [DEPTH_W-1:0]     r_depth;
    logic [DEPTH_W-1:0]     n_depth;
    logic [DEPTH_W-1:0]     top_idx;

    assign top_idx = r_depth - DEPTH_W'(1);
    assign o_data  = r_rd;

    always_comb begin
        n_depth = r_depth;
        if (i_ctl.clear) begin
            n_depth = '0;
        end else if (i_ctl.push && (r_depth != DEPTH_W'(TOKEN_COUNT))) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (i_ctl.pop && (r_depth != '0)) begin
            n_depth = top_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear && (r_depth != DEPTH_W'(TOKEN_COUNT))) begin
            r_mem[r_depth[TOK_IDX_W-1:0]] <= i_data;
        end
        if (i_ctl.pop) begin
            if (r_depth != '0) begin
                r_rd <= r_mem[top_idx[TOK_IDX_W-1:0]];
            end else begin
                r_rd <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("stack push and pop in one cycle");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(TOKEN_COUNT))
        else $error("stack depth beyond capacity");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_depth == '0))
        else $error("stack not empty after clear");
`endif

endmodule

// File: sv/pee_alu.sv
// shared arithmetic unit of the prefix expression evaluator: add and subtract in one
// step, shift-add multiply and restoring divide one bit per cycle, wrapping arithmetic
// depends on pee_pkg
module pee_alu import pee_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_alu_req               i_req,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_result
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH);

    t_alu_state      r_state;
    t_alu_state      n_state;
    t_op             r_op;
    logic [VW-1:0]   r_acc;
    logic [VW-1:0]   r_x;
    logic [VW-1:0]   r_y;
    logic [VW-1:0]   r_rem;
    logic            r_neg;
    logic            r_zero;
    logic [CW-1:0]   r_cnt;
    logic [VW:0]     rem_sh;
    logic [VW:0]     diff;
    logic            last_step;

    assign rem_sh    = {r_rem, r_x[VW-1]};
    assign diff      = rem_sh - {1'b0, r_y};
    assign last_step = (r_op == OP_ADD) || (r_op == OP_SUB) || (r_cnt == CW'(VW - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_state = A_RUN;
                end
            end
            A_RUN: begin
                if (last_step) begin
                    n_state = A_DONE;
                end
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_done   = 1'b0;
        o_result = r_acc;
        unique case (r_state)
            A_DONE: begin
                o_done = 1'b1;
                if (r_op == OP_DIV) begin
                    if (r_zero) begin
                        o_result = '0;
                    end else if (r_neg) begin
                        o_result = '0 - r_x;
                    end else begin
                        o_result = r_x;
                    end
                end
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == A_IDLE && i_req.start) begin
            r_op   <= i_req.op;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_rem  <= '0;
            r_neg  <= i_a[VW-1] ^ i_b[VW-1];
            r_zero <= (i_b == '0);
            if (i_req.op == OP_DIV) begin
                r_x <= i_a[VW-1] ? ('0 - i_a) : i_a;
                r_y <= i_b[VW-1] ? ('0 - i_b) : i_b;
            end else begin
                r_x <= i_a;
                r_y <= i_b;
            end
        end else if (r_state == A_RUN) begin
            r_cnt <= r_cnt + CW'(1);
            case (r_op)
                OP_ADD: begin
                    r_acc <= r_x + r_y;
                end
                OP_SUB: begin
                    r_acc <= r_x - r_y;
                end
                OP_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= {r_x[VW-2:0], 1'b0};
                    r_y <= {1'b0, r_y[VW-1:1]};
                end
                default: begin
                    if (!diff[VW]) begin
                        r_rem <= diff[VW-1:0];
                    end else begin
                        r_rem <= rem_sh[VW-1:0];
                    end
                    r_x <= {r_x[VW-2:0], !diff[VW]};
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("arithmetic done held for more than one cycle");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == A_IDLE))
        else $error("arithmetic unit started while busy");
    a_add_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_RUN && (r_op == OP_ADD || r_op == OP_SUB)) |=> o_done)
        else $error("add or subtract took more than one step");
`endif

endmodule

// File: sv/prefix_expression_evaluator.sv
// prefix expression evaluator top level: token sequencer over the operand stack and the
// shared arithmetic unit; depends on pee_pkg, pee_stack and pee_alu
// tokens are scanned from token 7 down to token 0: a digit or x is pushed, an unused code
// is skipped, and + - * / pop two operands, run the arithmetic unit and push its result
// throughput: one transaction at a time, busy high through the o_valid cycle;
// reset: synchronous active-low, idle with stack empty
module prefix_expression_evaluator import pee_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [TOKEN_W-1:0]         i_token_0,
    input  logic [TOKEN_W-1:0]         i_token_1,
    input  logic [TOKEN_W-1:0]         i_token_2,
    input  logic [TOKEN_W-1:0]         i_token_3,
    input  logic [TOKEN_W-1:0]         i_token_4,
    input  logic [TOKEN_W-1:0]         i_token_5,
    input  logic [TOKEN_W-1:0]         i_token_6,
    input  logic [TOKEN_W-1:0]         i_token_7,
    input  logic signed [X_W-1:0]      i_x_value,
    output logic                       o_valid,
    output logic signed [RESULT_W-1:0] o_result_value
);

    localparam int VW = VALUE_WIDTH;

    t_seq_state          r_state;
    t_seq_state          n_state;
    logic [TOKEN_W-1:0]  r_tok [TOKEN_COUNT];
    logic [VW-1:0]       r_x;
    logic [TOK_IDX_W-1:0] r_idx;
    t_op                 r_op;
    logic [VW-1:0]       r_a;
    logic [TOKEN_W-1:0]  cur_tok;
    logic                is_op;
    logic                is_val;
    logic                last_tok;
    t_op                 tok_op;
    t_stk_ctl            stk_ctl;
    logic [VW-1:0]       stk_wdata;
    logic [VW-1:0]       stk_rdata;
    t_alu_req            alu_req;
    logic                alu_done;
    logic [VW-1:0]       alu_result;

    assign cur_tok  = r_tok[r_idx];
    assign is_op    = (cur_tok >= TK_ADD) && (cur_tok <= TK_DIV);
    assign is_val   = (cur_tok <= TK_X);
    assign last_tok = (r_idx == '0);

    always_comb begin
        unique case (cur_tok)
            TK_SUB:  tok_op = OP_SUB;
            TK_MUL:  tok_op = OP_MUL;
            TK_DIV:  tok_op = OP_DIV;
            default: tok_op = OP_ADD;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_TOKEN;
                end
            end
            S_TOKEN: begin
                if (is_op) begin
                    n_state = S_POP_B;
                end else if (last_tok) begin
                    n_state = S_FINAL;
                end
            end
            S_POP_B: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_ALU;
            end
            S_ALU: begin
                if (alu_done) begin
                    n_state = last_tok ? S_FINAL : S_TOKEN;
                end
            end
            S_FINAL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy           = 1'b1;
        o_valid        = 1'b0;
        o_result_value = RESULT_W'($signed(stk_rdata));
        stk_ctl        = '0;
        stk_wdata      = alu_result;
        alu_req.start  = 1'b0;
        alu_req.op     = r_op;
        unique case (r_state)
            S_IDLE: begin
                busy          = 1'b0;
                stk_ctl.clear = start;
            end
            S_TOKEN: begin
                stk_ctl.pop  = is_op;
                stk_ctl.push = is_val;
                if (cur_tok == TK_X) begin
                    stk_wdata = r_x;
                end else begin
                    stk_wdata = VW'(cur_tok);
                end
            end
            S_POP_B: begin
                stk_ctl.pop = 1'b1;
            end
            S_LOAD: begin
                alu_req.start = 1'b1;
            end
            S_ALU: begin
                stk_ctl.push = alu_done;
            end
            S_FINAL: begin
                stk_ctl.pop = 1'b1;
            end
            S_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_tok[0] <= i_token_0;
            r_tok[1] <= i_token_1;
            r_tok[2] <= i_token_2;
            r_tok[3] <= i_token_3;
            r_tok[4] <= i_token_4;
            r_tok[5] <= i_token_5;
            r_tok[6] <= i_token_6;
            r_tok[7] <= i_token_7;
            r_x      <= VW'(i_x_value);
            r_idx    <= TOK_IDX_W'(TOKEN_COUNT - 1);
        end
        if (r_state == S_TOKEN) begin
            r_op <= tok_op;
            if (!is_op) begin
                r_idx <= r_idx - TOK_IDX_W'(1);
            end
        end
        if (r_state == S_POP_B) begin
            r_a <= stk_rdata;
        end
        if (r_state == S_ALU && alu_done) begin
            r_idx <= r_idx - TOK_IDX_W'(1);
        end
    end

    pee_stack #(
        .VALUE_WIDTH(VW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (stk_ctl),
        .i_data (stk_wdata),
        .o_data (stk_rdata)
    );

    pee_alu #(
        .VALUE_WIDTH(VW)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_a),
        .i_b     (stk_rdata),
        .o_done  (alu_done),
        .o_result(alu_result)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but not busy");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe not a single cycle before idle");
    a_alu_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_ALU))
        else $error("arithmetic result arrived outside its wait state");
`endif

endmodule
